// ----- rtl/core/ettv_pkg.sv -----
package ettv_pkg;

    // Field widths.
    localparam int ANGLE_BITS = 12;
    localparam int TURN_BITS  = 16;
    localparam int TIME_BITS  = 32;

    // Multiturn position and velocity arithmetic.
    localparam int TOTAL_BITS = TURN_BITS + ANGLE_BITS + 1;
    localparam int MAG_BITS   = TURN_BITS + ANGLE_BITS;
    localparam int VEL_BITS   = 32;

    // Microseconds per second, applied bit-serially.
    localparam int                    SCALE_BITS = 20;
    localparam logic [SCALE_BITS-1:0] SCALE      = SCALE_BITS'(1000000);
    localparam int                    PROD_BITS  = MAG_BITS + SCALE_BITS;

    // Configuration registers.
    localparam int JUMP_BITS      = ANGLE_BITS;
    localparam int ZERO_BITS      = 20;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 1;
    localparam int DVSR_BITS      = (TIME_BITS > ZERO_BITS) ? TIME_BITS : ZERO_BITS;

    localparam logic [JUMP_BITS-1:0] JUMP_RESET = JUMP_BITS'(3276);
    localparam logic [ZERO_BITS-1:0] ZERO_RESET = ZERO_BITS'(1000);

    localparam logic [CFG_INDEX_BITS-1:0] REG_JUMP_THRESHOLD = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_INTERVAL  = CFG_INDEX_BITS'(1);

    // Iteration counters.
    localparam int MUL_CNT_BITS = $clog2(SCALE_BITS);
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS);

    // Opcodes.
    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_SAMPLE   = 2'd0;
    localparam opcode_t OP_VELOCITY = 2'd1;
    localparam opcode_t OP_SEED     = 2'd2;

    typedef struct packed {
        opcode_t               opcode;
        logic [ANGLE_BITS-1:0] sample_angle;
        logic [TIME_BITS-1:0]  sample_time_us;
    } req_t;

    typedef struct packed {
        logic signed [TOTAL_BITS-1:0] total_angle;
        logic [ANGLE_BITS-1:0]        last_angle_out;
        logic signed [TURN_BITS-1:0]  turns_out;
        logic signed [VEL_BITS-1:0]   velocity;
        logic                         velocity_valid;
    } rsp_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] last_angle;
        logic [TIME_BITS-1:0]  last_time;
        logic [TURN_BITS-1:0]  turn_count;
        logic [ANGLE_BITS-1:0] ref_angle;
        logic [TIME_BITS-1:0]  ref_time;
        logic [TURN_BITS-1:0]  ref_turns;
    } trk_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/core/ettv_track.sv -----
// Holds the tracked angle, time and turn count together with the velocity
// references, and applies one transaction's update to them.
module ettv_track (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  ettv_pkg::req_t                   req,
    input  logic [ettv_pkg::JUMP_BITS-1:0]   jump_threshold,
    output ettv_pkg::trk_state_t             trk,
    output ettv_pkg::trk_state_t             trk_upd
);

    ettv_pkg::trk_state_t                  trk_reg;
    ettv_pkg::trk_state_t                  trk_next;
    logic signed [ettv_pkg::ANGLE_BITS:0]  jump_diff;
    logic [ettv_pkg::ANGLE_BITS-1:0]       jump_mag;
    logic                                  big_jump;

    assign jump_diff = $signed({1'b0, req.sample_angle}) - $signed({1'b0, trk_reg.last_angle});
    assign jump_mag  = jump_diff[ettv_pkg::ANGLE_BITS]
                       ? ettv_pkg::ANGLE_BITS'(-jump_diff)
                       : jump_diff[ettv_pkg::ANGLE_BITS-1:0];
    assign big_jump  = jump_mag > jump_threshold;

    always_comb
    begin
        trk_upd = trk_reg;
        case (req.opcode)
            ettv_pkg::OP_SAMPLE:
            begin
                if (big_jump)
                begin
                    if (jump_diff[ettv_pkg::ANGLE_BITS])
                    begin
                        trk_upd.turn_count = trk_reg.turn_count - ettv_pkg::TURN_BITS'(1);
                    end
                    else
                    begin
                        trk_upd.turn_count = trk_reg.turn_count + ettv_pkg::TURN_BITS'(1);
                    end
                end
                trk_upd.last_angle = req.sample_angle;
                trk_upd.last_time  = req.sample_time_us;
            end
            ettv_pkg::OP_VELOCITY:
            begin
                trk_upd.ref_angle = trk_reg.last_angle;
                trk_upd.ref_time  = trk_reg.last_time;
                trk_upd.ref_turns = trk_reg.turn_count;
            end
            ettv_pkg::OP_SEED:
            begin
                trk_upd.ref_angle  = req.sample_angle;
                trk_upd.ref_time   = req.sample_time_us;
                trk_upd.last_angle = req.sample_angle;
                trk_upd.last_time  = req.sample_time_us;
            end
            default:
            begin
                trk_upd = trk_reg;
            end
        endcase
    end

    assign trk_next = accept ? trk_upd : trk_reg;
    assign trk      = trk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_reg <= '0;
        end
        else
        begin
            trk_reg <= trk_next;
        end
    end

endmodule

// ----- rtl/core/ettv_mul.sv -----
// Multiplies the position change by one million, one bit of the constant
// per cycle, most significant bit first.
module ettv_mul (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ettv_pkg::MAG_BITS-1:0]    mag,
    output logic                             done,
    output logic [ettv_pkg::PROD_BITS-1:0]   product
);

    logic [ettv_pkg::MAG_BITS-1:0]     mag_reg;
    logic [ettv_pkg::MAG_BITS-1:0]     mag_next;
    logic [ettv_pkg::PROD_BITS-1:0]    acc_reg;
    logic [ettv_pkg::PROD_BITS-1:0]    acc_next;
    logic [ettv_pkg::MUL_CNT_BITS-1:0] cnt_reg;
    logic [ettv_pkg::MUL_CNT_BITS-1:0] cnt_next;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [ettv_pkg::PROD_BITS-1:0]    addend;

    assign addend = ettv_pkg::SCALE[cnt_reg] ? ettv_pkg::PROD_BITS'(mag_reg) : '0;

    always_comb
    begin
        mag_next  = mag_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = mag;
            acc_next  = '0;
            cnt_next  = ettv_pkg::MUL_CNT_BITS'(ettv_pkg::SCALE_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[ettv_pkg::PROD_BITS-2:0], 1'b0} + addend;
            cnt_next = cnt_reg - ettv_pkg::MUL_CNT_BITS'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- rtl/core/ettv_div.sv -----
// Restoring divider: one quotient bit per cycle, the dividend shifting out
// of the same register that the quotient shifts into.
module ettv_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ettv_pkg::PROD_BITS-1:0]   dividend,
    input  logic [ettv_pkg::DVSR_BITS-1:0]   divisor,
    output logic                             done,
    output logic [ettv_pkg::PROD_BITS-1:0]   quotient
);

    logic [ettv_pkg::PROD_BITS-1:0]    dq_reg;
    logic [ettv_pkg::PROD_BITS-1:0]    dq_next;
    logic [ettv_pkg::DVSR_BITS-1:0]    rem_reg;
    logic [ettv_pkg::DVSR_BITS-1:0]    rem_next;
    logic [ettv_pkg::DVSR_BITS-1:0]    dvsr_reg;
    logic [ettv_pkg::DVSR_BITS-1:0]    dvsr_next;
    logic [ettv_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic [ettv_pkg::DIV_CNT_BITS-1:0] cnt_next;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [ettv_pkg::DVSR_BITS:0]      trial;
    logic [ettv_pkg::DVSR_BITS:0]      diff;
    logic                              fits;

    assign trial = {rem_reg, dq_reg[ettv_pkg::PROD_BITS-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
            cnt_next  = ettv_pkg::DIV_CNT_BITS'(ettv_pkg::PROD_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder always stays below the divisor.
            rem_next = fits ? diff[ettv_pkg::DVSR_BITS-1:0] : trial[ettv_pkg::DVSR_BITS-1:0];
            dq_next  = {dq_reg[ettv_pkg::PROD_BITS-2:0], fits};
            cnt_next = cnt_reg - ettv_pkg::DIV_CNT_BITS'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ----- rtl/core/encoder_turn_tracker_velocity.sv -----
// Latency: sample, seed and unused-opcode transactions reach the result register one cycle
// after acceptance, and may follow each other in consecutive cycles.
// A velocity read reaches the result register after the bit-serial multiply by one million,
// the restoring divide and a hand-over through the done state.
// No new request is taken until a velocity read's result has been loaded.
// Reset: asynchronous, active low; tracked state clears to zero and registers take defaults.
module encoder_turn_tracker_velocity (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [ettv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ettv_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  ettv_pkg::req_t                        req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output ettv_pkg::rsp_t                        rsp
);

    // Configuration registers.
    logic [ettv_pkg::JUMP_BITS-1:0]        jump_reg;
    logic [ettv_pkg::JUMP_BITS-1:0]        jump_next;
    logic [ettv_pkg::ZERO_BITS-1:0]        zero_reg;
    logic [ettv_pkg::ZERO_BITS-1:0]        zero_next;

    // Sequencer.
    ettv_pkg::state_t                      state_reg;
    ettv_pkg::state_t                      state_next;
    logic                                  req_fire;
    logic                                  is_velocity;
    logic                                  out_free;
    logic                                  mul_start;
    logic                                  div_start;
    logic                                  done_load;

    // Tracker view.
    ettv_pkg::trk_state_t                  trk;
    ettv_pkg::trk_state_t                  trk_upd;

    // Velocity operands.
    logic [ettv_pkg::TIME_BITS-1:0]        elapsed;
    logic [ettv_pkg::DVSR_BITS-1:0]        divisor_sel;
    logic signed [ettv_pkg::TURN_BITS:0]   dturn;
    logic signed [ettv_pkg::ANGLE_BITS:0]  dang;
    logic signed [ettv_pkg::TOTAL_BITS-1:0] num;
    logic [ettv_pkg::MAG_BITS-1:0]         mag;
    logic [ettv_pkg::DVSR_BITS-1:0]        divisor_reg;
    logic [ettv_pkg::DVSR_BITS-1:0]        divisor_next;
    logic                                  neg_reg;
    logic                                  neg_next;

    // Serial units.
    logic                                  mul_done;
    logic [ettv_pkg::PROD_BITS-1:0]        product;
    logic                                  div_done;
    logic [ettv_pkg::PROD_BITS-1:0]        quotient;
    logic [ettv_pkg::VEL_BITS-1:0]         vel_sat;
    logic                                  q_above_pos;
    logic                                  q_above_neg;

    // Result register.
    ettv_pkg::rsp_t                        rsp_reg;
    ettv_pkg::rsp_t                        rsp_next;
    logic                                  rsp_valid_reg;
    logic                                  rsp_valid_next;
    logic signed [ettv_pkg::TURN_BITS:0]   neg_turns_upd;
    logic signed [ettv_pkg::TURN_BITS:0]   neg_turns_cur;

    // ------------------------------------------------------------------
    // Configuration writes take effect at once; the user must write only while the block is
    // idle, so that no transaction in flight sees a change. The block does not enforce this.
    // ------------------------------------------------------------------
    always_comb
    begin
        jump_next = jump_reg;
        zero_next = zero_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                ettv_pkg::REG_JUMP_THRESHOLD:
                begin
                    jump_next = cfg_wdata[ettv_pkg::JUMP_BITS-1:0];
                end
                ettv_pkg::REG_ZERO_INTERVAL:
                begin
                    zero_next = cfg_wdata[ettv_pkg::ZERO_BITS-1:0];
                end
                default:
                begin
                    jump_next = jump_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and sequencer. Only a velocity read leaves the idle state;
    // every other transaction completes in the cycle it is accepted, as
    // long as the result register is free or being emptied.
    // ------------------------------------------------------------------
    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign is_velocity = req.opcode == ettv_pkg::OP_VELOCITY;
    assign req_fire    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ettv_pkg::ST_IDLE:
            begin
                if (req_fire && is_velocity)
                begin
                    state_next = ettv_pkg::ST_MUL;
                end
            end
            ettv_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ettv_pkg::ST_DIV;
                end
            end
            ettv_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ettv_pkg::ST_DONE;
                end
            end
            ettv_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ettv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ettv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        div_start = 1'b0;
        done_load = 1'b0;
        case (state_reg)
            ettv_pkg::ST_IDLE:
            begin
                req_ready = out_free;
            end
            ettv_pkg::ST_MUL:
            begin
                div_start = mul_done;
            end
            ettv_pkg::ST_DIV:
            begin
                req_ready = 1'b0;
            end
            ettv_pkg::ST_DONE:
            begin
                done_load = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign mul_start = req_fire && is_velocity;

    // ------------------------------------------------------------------
    // Turn tracking and reference state.
    // ------------------------------------------------------------------
    ettv_track u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (req_fire),
        .req            (req),
        .jump_threshold (jump_reg),
        .trk            (trk),
        .trk_upd        (trk_upd)
    );

    // ------------------------------------------------------------------
    // Velocity operands, taken from the state before the references are
    // latched. The position change is formed exactly in sign and magnitude;
    // the sign is held aside while the magnitude goes through the serial
    // multiplier and divider. A zero interval falls back to the configured
    // value, and a zero fallback to one microsecond.
    // ------------------------------------------------------------------
    assign elapsed = trk.last_time - trk.ref_time;

    always_comb
    begin
        if (elapsed != '0)
        begin
            divisor_sel = ettv_pkg::DVSR_BITS'(elapsed);
        end
        else if (zero_reg != '0)
        begin
            divisor_sel = ettv_pkg::DVSR_BITS'(zero_reg);
        end
        else
        begin
            divisor_sel = ettv_pkg::DVSR_BITS'(1);
        end
    end

    assign dturn = $signed({trk.turn_count[ettv_pkg::TURN_BITS-1], trk.turn_count})
                 - $signed({trk.ref_turns[ettv_pkg::TURN_BITS-1], trk.ref_turns});
    assign dang  = $signed({1'b0, trk.last_angle}) - $signed({1'b0, trk.ref_angle});
    assign num   = $signed({dturn, {ettv_pkg::ANGLE_BITS{1'b0}}})
                 - $signed({{(ettv_pkg::TOTAL_BITS-ettv_pkg::ANGLE_BITS-1){dang[ettv_pkg::ANGLE_BITS]}},
                            dang});
    assign mag   = num[ettv_pkg::TOTAL_BITS-1]
                   ? ettv_pkg::MAG_BITS'(-num)
                   : num[ettv_pkg::MAG_BITS-1:0];

    assign divisor_next = mul_start ? divisor_sel : divisor_reg;
    assign neg_next     = mul_start ? num[ettv_pkg::TOTAL_BITS-1] : neg_reg;

    ettv_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mag     (mag),
        .done    (mul_done),
        .product (product)
    );

    ettv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // Saturation of the truncated quotient to the signed 32-bit range. The
    // negative side reaches one step further than the positive side.
    // ------------------------------------------------------------------
    assign q_above_pos = |quotient[ettv_pkg::PROD_BITS-1:ettv_pkg::VEL_BITS-1];
    assign q_above_neg = (|quotient[ettv_pkg::PROD_BITS-1:ettv_pkg::VEL_BITS])
                       || (quotient[ettv_pkg::VEL_BITS-1]
                           && (|quotient[ettv_pkg::VEL_BITS-2:0]));

    always_comb
    begin
        if (neg_reg)
        begin
            if (q_above_neg)
            begin
                vel_sat = {1'b1, {(ettv_pkg::VEL_BITS-1){1'b0}}};
            end
            else
            begin
                vel_sat = -quotient[ettv_pkg::VEL_BITS-1:0];
            end
        end
        else
        begin
            if (q_above_pos)
            begin
                vel_sat = {1'b0, {(ettv_pkg::VEL_BITS-1){1'b1}}};
            end
            else
            begin
                vel_sat = quotient[ettv_pkg::VEL_BITS-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register. The total angle is minus the turn count times a
    // full turn plus the single-turn angle; since the angle fills exactly
    // the low bits, it is the negated count placed above the angle.
    // The tracker state does not move during a velocity read, so the
    // position fields of that result come from the current state.
    // ------------------------------------------------------------------
    assign neg_turns_upd = -$signed({trk_upd.turn_count[ettv_pkg::TURN_BITS-1],
                                     trk_upd.turn_count});
    assign neg_turns_cur = -$signed({trk.turn_count[ettv_pkg::TURN_BITS-1], trk.turn_count});

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (req_fire && !is_velocity)
        begin
            rsp_next.total_angle    = $signed({neg_turns_upd, trk_upd.last_angle});
            rsp_next.last_angle_out = trk_upd.last_angle;
            rsp_next.turns_out      = $signed(trk_upd.turn_count);
            rsp_next.velocity       = '0;
            rsp_next.velocity_valid = 1'b0;
            rsp_valid_next          = 1'b1;
        end
        else if (done_load)
        begin
            rsp_next.total_angle    = $signed({neg_turns_cur, trk.last_angle});
            rsp_next.last_angle_out = trk.last_angle;
            rsp_next.turns_out      = $signed(trk.turn_count);
            rsp_next.velocity       = $signed(vel_sat);
            rsp_next.velocity_valid = 1'b1;
            rsp_valid_next          = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_reg      <= ettv_pkg::JUMP_RESET;
            zero_reg      <= ettv_pkg::ZERO_RESET;
            state_reg     <= ettv_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            jump_reg      <= jump_next;
            zero_reg      <= zero_next;
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    // The multiplier only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ettv_pkg::ST_MUL)
        else $error("multiplier finished outside the multiply phase");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ettv_pkg::ST_DIV)
        else $error("divider finished outside the divide phase");

    // An accepted velocity read always starts the serial multiply.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.opcode == ettv_pkg::OP_VELOCITY)
        |=> state_reg == ettv_pkg::ST_MUL)
        else $error("velocity read did not start the multiplier");

    // A result that does not answer a velocity read carries zero velocity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.velocity_valid) |-> rsp_reg.velocity == '0)
        else $error("non-velocity result with non-zero velocity");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the multiturn angle tracker and velocity estimator.
// A behavioural copy of the tracker runs alongside the block: every request transaction
// that the block accepts is applied to it, and the report it predicts is queued. Each
// report transaction that leaves the block is compared, field by field, with the oldest
// queued prediction.
module tb_top;

    import ettv_pkg::*;

    // The opcode that the block must ignore has no name in the package.
    localparam opcode_t OP_UNUSED = 2'd3;

    localparam longint ANGLE_SPAN     = longint'(1) << ANGLE_BITS;
    localparam longint USEC_PER_SEC   = 1000000;
    localparam longint VEL_POS_LIMIT  = 64'sd2147483647;
    localparam longint VEL_NEG_LIMIT  = 64'sd2147483648;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     PRINT_LIMIT    = 40;

    // Clock and reset. Reset is held low from the start and never asserted again.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    // Every input of the block starts from a known value.
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      req_valid = 1'b0;
    logic                      req_ready;
    req_t                      req_bus   = '0;
    logic                      rsp_valid;
    logic                      rsp_ready = 1'b0;
    rsp_t                      rsp_bus;

    encoder_turn_tracker_velocity DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_bus),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_bus)
    );

    // Shadow of the tracker: its state and its two registers, as they stand after reset.
    trk_state_t           track           = '0;
    logic [JUMP_BITS-1:0] jump_limit      = JUMP_RESET;
    logic [ZERO_BITS-1:0] zero_fallback_us = ZERO_RESET;

    // Reports predicted for accepted requests and not yet seen at the output.
    rsp_t tracker_reports[$];

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int velocity_reads  = 0;
    int quiet_cycles    = 0;

    // Idling controls. The enable is shared by sender and receiver; the hold request asks the
    // receiver for one long stretch with ready low; the receiver counts it down itself.
    bit idle_enable  = 1'b0;
    int hold_request = 0;

    // Applies one request to the shadow tracker and returns the report it should produce.
    function automatic rsp_t advance_tracker(input req_t item);
        rsp_t               res;
        longint             delta;
        longint             jump_mag;
        longint             turn_diff;
        longint             num;
        longint             mag;
        longint             quot;
        longint             divisor;
        logic [TIME_BITS-1:0] elapsed;
        res = '0;
        case (item.opcode)
            OP_SAMPLE:
            begin
                delta    = longint'(item.sample_angle) - longint'(track.last_angle);
                jump_mag = (delta < 0) ? -delta : delta;
                if (jump_mag > longint'(jump_limit))
                begin
                    if (delta < 0)
                        track.turn_count = track.turn_count - TURN_BITS'(1);
                    else
                        track.turn_count = track.turn_count + TURN_BITS'(1);
                end
                track.last_angle = item.sample_angle;
                track.last_time  = item.sample_time_us;
            end
            OP_VELOCITY:
            begin
                // Elapsed time wraps with the free-running timestamp.
                elapsed = track.last_time - track.ref_time;
                divisor = (elapsed != '0) ? longint'(elapsed) : longint'(zero_fallback_us);
                if (divisor == 0)
                    divisor = 1;
                turn_diff = longint'($signed(track.turn_count)) -
                            longint'($signed(track.ref_turns));
                num = turn_diff * ANGLE_SPAN -
                      (longint'(track.last_angle) - longint'(track.ref_angle));
                mag  = (num < 0) ? -num : num;
                quot = (mag * USEC_PER_SEC) / divisor;
                if (num < 0)
                begin
                    if (quot > VEL_NEG_LIMIT)
                        quot = VEL_NEG_LIMIT;
                    res.velocity = VEL_BITS'(-quot);
                end
                else
                begin
                    if (quot > VEL_POS_LIMIT)
                        quot = VEL_POS_LIMIT;
                    res.velocity = VEL_BITS'(quot);
                end
                res.velocity_valid = 1'b1;
                track.ref_angle = track.last_angle;
                track.ref_turns = track.turn_count;
                track.ref_time  = track.last_time;
            end
            OP_SEED:
            begin
                track.ref_angle  = item.sample_angle;
                track.ref_time   = item.sample_time_us;
                track.last_angle = item.sample_angle;
                track.last_time  = item.sample_time_us;
            end
            default:
            begin
            end
        endcase
        res.total_angle = TOTAL_BITS'(longint'(track.last_angle) -
                                      longint'($signed(track.turn_count)) * ANGLE_SPAN);
        res.last_angle_out = track.last_angle;
        res.turns_out      = track.turn_count;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, what);
        error_count++;
    endtask

    // Sender: optionally idles for a short burst, then offers one request transaction and
    // holds it until the block takes it. Valid is left high afterwards so that a following
    // transaction can go out in the very next cycle.
    task automatic send_request(input opcode_t op, input logic [ANGLE_BITS-1:0] angle,
                                input logic [TIME_BITS-1:0] stamp);
        req_t item;
        int   gap;
        item.opcode         = op;
        item.sample_angle   = angle;
        item.sample_time_us = stamp;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_bus   <= item;
        do
            @(posedge clk);
        while (!req_ready);
        tracker_reports.push_back(advance_tracker(item));
        items_sent++;
        if (op == OP_VELOCITY)
            velocity_reads++;
    endtask

    // Stops offering requests and waits until every predicted report has come back, then
    // leaves a few cycles so that nothing is left in flight.
    task automatic settle_tracker();
        req_valid <= 1'b0;
        while (tracker_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes happen only with the block drained and idle.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input int unsigned value);
        settle_tracker();
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= CFG_DATA_BITS'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index == REG_JUMP_THRESHOLD)
            jump_limit = JUMP_BITS'(value);
        else
            zero_fallback_us = ZERO_BITS'(value);
    endtask

    // Receiver: ready drops in short random bursts while idling is enabled, and for one
    // long stretch whenever a test asks for it.
    always @(posedge clk)
    begin
        static int hold_left  = 0;
        static int stall_left = 0;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Checker: every report transaction is matched against the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (tracker_reports.size() == 0)
                report_mismatch($sformatf("report %h arrived with nothing outstanding",
                                          rsp_bus));
            else
            begin
                want = tracker_reports.pop_front();
                if (rsp_bus.total_angle !== want.total_angle)
                    report_mismatch($sformatf("report %0d total_angle: got %0d, want %0d",
                                              results_checked, rsp_bus.total_angle,
                                              want.total_angle));
                if (rsp_bus.last_angle_out !== want.last_angle_out)
                    report_mismatch($sformatf("report %0d last_angle_out: got %0d, want %0d",
                                              results_checked, rsp_bus.last_angle_out,
                                              want.last_angle_out));
                if (rsp_bus.turns_out !== want.turns_out)
                    report_mismatch($sformatf("report %0d turns_out: got %0d, want %0d",
                                              results_checked, rsp_bus.turns_out,
                                              want.turns_out));
                if (rsp_bus.velocity !== want.velocity)
                    report_mismatch($sformatf("report %0d velocity: got %0d, want %0d",
                                              results_checked, rsp_bus.velocity,
                                              want.velocity));
                if (rsp_bus.velocity_valid !== want.velocity_valid)
                    report_mismatch($sformatf("report %0d velocity_valid: got %b, want %b",
                                              results_checked, rsp_bus.velocity_valid,
                                              want.velocity_valid));
            end
            results_checked++;
        end
    end

    // Watchdog: the run is abandoned after a long spell in which neither channel moves a
    // transaction. The longest correct spell is the deliberate receiver hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A velocity read straight out of reset: zero elapsed time falls back to the register,
    // and the unused opcode must leave everything alone.
    task automatic test_reset_and_unused_opcode();
        send_request(OP_VELOCITY, 12'hFFF, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 12'hABC, 32'h1234_5678);
        send_request(OP_UNUSED, 12'h543, 32'hEDCB_A987);
    endtask

    // Jumps on either side of the default threshold, in both directions.
    task automatic test_turn_threshold();
        send_request(OP_SAMPLE, 12'd4095, 32'd1);   // full positive jump: one turn up
        send_request(OP_SAMPLE, 12'd0, 32'd2);      // full negative jump: one turn down
        send_request(OP_SAMPLE, 12'd3276, 32'd3);   // exactly at the threshold: no count
        send_request(OP_SAMPLE, 12'd0, 32'd4);
        send_request(OP_SAMPLE, 12'd3277, 32'd5);   // one count above: counts
        send_request(OP_SAMPLE, 12'd0, 32'd5);
        settle_tracker();
    endtask

    // Fallback interval, saturation in both directions and a timestamp that wraps.
    task automatic test_velocity_cases();
        idle_enable = 1'b1;
        send_request(OP_SEED, 12'd100, 32'd1000);
        send_request(OP_SAMPLE, 12'd200, 32'd1000);
        send_request(OP_VELOCITY, 12'd0, 32'd0);            // zero elapsed time
        send_request(OP_SEED, 12'd0, 32'd0);
        send_request(OP_SAMPLE, 12'd2500, 32'd1);
        send_request(OP_VELOCITY, 12'd0, 32'd0);            // saturates negative
        send_request(OP_SEED, 12'd2500, 32'd10);
        send_request(OP_SAMPLE, 12'd0, 32'd11);
        send_request(OP_VELOCITY, 12'd0, 32'd0);            // saturates positive
        send_request(OP_SEED, 12'd100, 32'hFFFF_FF00);
        send_request(OP_SAMPLE, 12'd50, 32'h0000_0100);
        send_request(OP_VELOCITY, 12'hFFF, 32'hFFFF_FFFF); // elapsed across the wrap
        settle_tracker();
    endtask

    // Both registers at their extremes, including a zero fallback interval.
    task automatic test_register_extremes();
        write_register(REG_ZERO_INTERVAL, 0);
        send_request(OP_SEED, 12'd10, 32'd50);
        send_request(OP_SAMPLE, 12'd20, 32'd50);
        send_request(OP_VELOCITY, 12'd0, 32'd0);
        write_register(REG_ZERO_INTERVAL, 1000000);
        send_request(OP_SAMPLE, 12'd4000, 32'd50);
        send_request(OP_VELOCITY, 12'd0, 32'd0);
        write_register(REG_ZERO_INTERVAL, 20'hFFFFF);
        send_request(OP_VELOCITY, 12'd0, 32'd0);
        write_register(REG_JUMP_THRESHOLD, 1);
        send_request(OP_SAMPLE, 12'd2, 32'd60);
        send_request(OP_SAMPLE, 12'd3, 32'd61);
        send_request(OP_SAMPLE, 12'd5, 32'd62);
        write_register(REG_JUMP_THRESHOLD, 4095);
        send_request(OP_SAMPLE, 12'd4095, 32'd63);
        send_request(OP_SAMPLE, 12'd0, 32'd64);
        write_register(REG_JUMP_THRESHOLD, 3276);
        write_register(REG_ZERO_INTERVAL, 1);
    endtask

    // Drives the turn count up through a run of full turns, back to back. Each pair of
    // samples rises by more than the threshold and falls back by exactly the threshold, so
    // only the rise counts; the angle creeps upward and is re-seeded before it runs out.
    task automatic test_turn_count_climb();
        int                   steps;
        int                   base;
        int                   done;
        logic [TIME_BITS-1:0] stamp;
        write_register(REG_JUMP_THRESHOLD, 2048);
        idle_enable = 1'b0;
        steps = 40;
        stamp = 32'h0000_1000;
        base  = 0;
        send_request(OP_SEED, 12'd0, stamp);
        for (done = 0; done < steps; done++)
        begin
            if (base > 2000)
            begin
                send_request(OP_SEED, 12'd0, stamp);
                base = 0;
            end
            stamp++;
            send_request(OP_SAMPLE, ANGLE_BITS'(base + 2049), stamp);
            stamp++;
            send_request(OP_SAMPLE, ANGLE_BITS'(base + 1), stamp);
            base++;
        end
        send_request(OP_VELOCITY, 12'd0, 32'd0);
        settle_tracker();
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the block
    // fills and stalls its input; afterwards the sender waits for every report.
    task automatic test_output_backpressure();
        int                   n;
        logic [TIME_BITS-1:0] stamp;
        write_register(REG_JUMP_THRESHOLD, 3276);
        write_register(REG_ZERO_INTERVAL, 1000);
        idle_enable  = 1'b0;
        hold_request = 300;
        stamp        = 32'd5000;
        for (n = 0; n < 30; n++)
        begin
            stamp = stamp + $urandom_range(1, 500);
            if (n % 5 == 4)
                send_request(OP_VELOCITY, ANGLE_BITS'($urandom), stamp);
            else
                send_request(OP_SAMPLE, ANGLE_BITS'(n * 397), stamp);
        end
        settle_tracker();
    endtask

    // Random traffic shaped like a rotating shaft: a random-walk angle sampled at uneven
    // intervals with velocity reads in between, plus seeds, ignored opcodes and samples
    // with arbitrary angle and timestamp. Registers change every few hundred transactions.
    task automatic test_random_traffic(input int quota, input bit bursty);
        int                   counted;
        int                   segment;
        int                   pick;
        int                   walk_angle;
        int                   walk_speed;
        int                   dt;
        logic [TIME_BITS-1:0] walk_time;
        counted    = 0;
        segment    = 0;
        walk_angle = $urandom_range(0, 4095);
        walk_speed = 0;
        walk_time  = $urandom;
        while (counted < quota)
        begin
            if (counted >= segment * 100)
            begin
                if (segment % 3 == 2)
                begin
                    case ($urandom_range(0, 3))
                        0: write_register(REG_JUMP_THRESHOLD, 1);
                        1: write_register(REG_JUMP_THRESHOLD, 4095);
                        2: write_register(REG_JUMP_THRESHOLD, $urandom_range(1, 4095));
                        default: write_register(REG_JUMP_THRESHOLD, $urandom_range(1500, 3600));
                    endcase
                    case ($urandom_range(0, 2))
                        0: write_register(REG_ZERO_INTERVAL, 1);
                        1: write_register(REG_ZERO_INTERVAL, 1000000);
                        default: write_register(REG_ZERO_INTERVAL, $urandom_range(1, 1000000));
                    endcase
                end
                // Some segments run with no idling at all.
                idle_enable = bursty && ($urandom_range(0, 9) < 7);
                segment++;
            end
            if ($urandom_range(0, 15) == 0)
                walk_speed = int'($urandom_range(0, 1200)) - 600;
            dt        = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3000);
            walk_time = walk_time + dt;
            pick      = $urandom_range(0, 99);
            if (pick < 68)
            begin
                walk_angle = (walk_angle + walk_speed + int'($urandom_range(0, 20)) - 10) & 4095;
                send_request(OP_SAMPLE, ANGLE_BITS'(walk_angle), walk_time);
                counted++;
            end
            else if (pick < 84)
            begin
                send_request(OP_VELOCITY, ANGLE_BITS'($urandom), $urandom);
                counted++;
            end
            else if (pick < 89)
            begin
                walk_angle = $urandom_range(0, 4095);
                send_request(OP_SEED, ANGLE_BITS'(walk_angle), walk_time);
                counted++;
            end
            else if (pick < 93)
                send_request(OP_UNUSED, ANGLE_BITS'($urandom), $urandom);
            else
            begin
                walk_angle = $urandom_range(0, 4095);
                walk_time  = $urandom;
                send_request(OP_SAMPLE, ANGLE_BITS'(walk_angle), walk_time);
                counted++;
            end
        end
        settle_tracker();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_and_unused_opcode();
        test_turn_threshold();
        test_velocity_cases();
        test_register_extremes();
        test_turn_count_climb();
        test_output_backpressure();
        test_random_traffic(1500, 1'b1);
        // The closing stretch runs with both sides always ready.
        test_random_traffic(200, 1'b0);

        settle_tracker();
        repeat (80) @(posedge clk);

        $display("Run covered %0d request transactions and %0d reports, %0d velocity reads.",
                 items_sent, results_checked, velocity_reads);
        $display("Included threshold edges, register extremes, turn runs, time wrap and stalls.");
        if (error_count == 0 && tracker_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
